@@ sv/tprmt_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tprmt_pkg
// Shared types and constants of the touchpad report to multitouch event block.
// ---------------------------------------------------------------------------
package tprmt_pkg;

   localparam int SLOT_COUNT     = 5;
   localparam int TRACK_ID_BITS  = 16;
   localparam int SLOT_W         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int RECORD_COUNT   = 5;
   localparam int RECORD_BITS    = 40;
   localparam int RANK_W         = 3;
   localparam int STATUS_SLOTS   = 5;
   localparam int STATUS_BASE    = 3;
   localparam int VALUE_BITS     = 17;
   localparam int CODE_BITS      = 4;
   localparam int REQ_DATA_BITS  = 216;
   localparam int RSP_DATA_BITS  = 24;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [7:0]  RESET_REPORT_ID  = 8'h5d;
   localparam logic [11:0] RESET_Y_FLIP     = 12'h6de;
   localparam logic [3:0]  RESET_PALM_MAJOR = 4'h8;
   localparam logic [7:0]  RESET_PALM_PRESS = 8'h80;

   localparam logic [VALUE_BITS-1:0] TOOL_FINGER = VALUE_BITS'(0);
   localparam logic [VALUE_BITS-1:0] TOOL_PALM   = VALUE_BITS'(2);

   typedef enum logic [CODE_BITS-1:0] {
      EV_SLOT     = 4'd0,
      EV_TRACK_ID = 4'd1,
      EV_TOOL     = 4'd2,
      EV_MT_X     = 4'd3,
      EV_MT_Y     = 4'd4,
      EV_MAJOR    = 4'd5,
      EV_PRESSURE = 4'd6,
      EV_X        = 4'd7,
      EV_Y        = 4'd8,
      EV_WIDTH    = 4'd9,
      EV_TOUCH    = 4'd10,
      EV_FINGER   = 4'd11,
      EV_BUTTON   = 4'd12,
      EV_SYNC     = 4'd13
   } event_code_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_REPORT_ID  = 2'd0,
      CSR_Y_FLIP     = 2'd1,
      CSR_PALM_MAJOR = 2'd2,
      CSR_PALM_PRESS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  report_id;
      logic [11:0] y_flip;
      logic [3:0]  palm_major;
      logic [7:0]  palm_press;
   } cfg_type;

   // What one slot lane found in the current report
   typedef struct packed {
      logic        report;
      logic        present;
      logic        first;
      logic        palm;
      logic        needs_new;
      logic [11:0] x;
      logic [12:0] y;
      logic [3:0]  major;
      logic [7:0]  press;
   } lane_type;

endpackage
`default_nettype wire

@@ sv/tprmt_lane.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tprmt_lane
// One slot lane: finds the slot's record, decodes it and decides whether the
// slot is reported and whether it needs a fresh tracking id.
// ---------------------------------------------------------------------------
module tprmt_lane (
   input  wire logic [tprmt_pkg::SLOT_W-1:0]      lane_idx,
   input  wire logic [7:0]                        status,
   input  wire logic [tprmt_pkg::RECORD_COUNT-1:0]
                     [tprmt_pkg::RECORD_BITS-1:0]  records,
   input  wire tprmt_pkg::cfg_type                cfg,
   input  wire logic                              active,
   input  wire logic                              is_palm,
   output tprmt_pkg::lane_type                    info
);
   import tprmt_pkg::*;

   logic [STATUS_SLOTS-1:0] slot_bits;
   logic [RANK_W-1:0]       rank;
   logic [RECORD_BITS-1:0]  rec;
   logic [7:0]              b0, b1, b2, b3, b4;
   logic [11:0]             raw_y;
   logic                    present;
   logic                    palm;

   always_comb begin
      slot_bits = status[STATUS_BASE +: STATUS_SLOTS];
      present   = slot_bits[lane_idx];
      // rank of this contact among the present slots below it
      rank = '0;
      for (int i = 0; i < STATUS_SLOTS; i++) begin
         if ((SLOT_W'(i) < lane_idx) && slot_bits[i]) begin
            rank = rank + RANK_W'(1);
         end
      end
      rec   = records[rank];
      b0    = rec[39:32];
      b1    = rec[31:24];
      b2    = rec[23:16];
      b3    = rec[15:8];
      b4    = rec[7:0];
      palm  = b3[7];
      raw_y = {b0[3:0], b2};

      info.report    = present || active;
      info.present   = present;
      info.first     = (rank == '0);
      info.palm      = present ? palm : is_palm;
      info.needs_new = present && (!active || (is_palm != palm));
      info.x         = {b0[7:4], b1};
      info.y         = {1'b0, cfg.y_flip} - {1'b0, raw_y};
      info.major     = palm ? cfg.palm_major : {1'b0, b3[6:4]};
      info.press     = palm ? cfg.palm_press : {1'b0, b4[6:0]};
   end

endmodule
`default_nettype wire

@@ sv/tprmt_emit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tprmt_emit
// Merging stage: captures the lane results of one report and walks them
// slot by slot, one event per cycle while rsp_tready does not hold it, into the output register.
// ---------------------------------------------------------------------------
module tprmt_emit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  load,
   input  wire tprmt_pkg::lane_type [tprmt_pkg::SLOT_COUNT-1:0] lanes,
   input  wire logic [tprmt_pkg::SLOT_COUNT-1:0]
                     [tprmt_pkg::TRACK_ID_BITS-1:0]    tids,
   input  wire logic                                  any_touch,
   input  wire logic                                  button,
   output logic                                       busy,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [tprmt_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   output logic                                       rsp_tlast
);
   import tprmt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SLOTS = 3'b010,
      ST_TAIL  = 3'b100
   } seq_state_type;

   seq_state_type                                state_ff, state_in;
   logic [SLOT_W-1:0]                            slot_ff, slot_in;
   event_code_type                               code_ff, code_in;
   lane_type [SLOT_COUNT-1:0]                    lanes_ff;
   logic [SLOT_COUNT-1:0][TRACK_ID_BITS-1:0]     tids_ff;
   logic                                         any_ff;
   logic                                         button_ff;

   logic                                         valid_ff, valid_in;
   event_code_type                               out_code_ff;
   logic [VALUE_BITS-1:0]                        out_value_ff, value;
   logic                                         out_last_ff;

   lane_type                                     cur;
   logic                                         adv;
   logic                                         emit;
   logic                                         emit_last;
   logic                                         slot_done;

   always_comb begin
      cur       = lanes_ff[slot_ff];
      adv       = !valid_ff || rsp_tready;
      state_in  = state_ff;
      slot_in   = slot_ff;
      code_in   = code_ff;
      emit      = 1'b0;
      emit_last = 1'b0;
      slot_done = 1'b0;
      slot_done = (code_ff == EV_TOOL && !cur.present) ||
                  (code_ff == EV_PRESSURE && !cur.first) ||
                  (code_ff == EV_WIDTH);

      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_SLOTS;
               slot_in  = '0;
               code_in  = EV_SLOT;
            end
         end
         ST_SLOTS: begin
            if (!cur.report || adv) begin
               emit = cur.report;
               if (!cur.report || slot_done) begin
                  // move on to the next slot, or to the closing events
                  if (slot_ff == SLOT_W'(SLOT_COUNT - 1)) begin
                     state_in = ST_TAIL;
                     code_in  = EV_TOUCH;
                  end else begin
                     slot_in = slot_ff + SLOT_W'(1);
                     code_in = EV_SLOT;
                  end
               end else begin
                  code_in = event_code_type'(code_ff + CODE_BITS'(1));
               end
            end
         end
         ST_TAIL: begin
            if (adv) begin
               emit = 1'b1;
               if (code_ff == EV_SYNC) begin
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  code_in = event_code_type'(code_ff + CODE_BITS'(1));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      unique case (code_ff)
         EV_SLOT:     value = VALUE_BITS'(slot_ff);
         EV_TRACK_ID: value = cur.present ? VALUE_BITS'(tids_ff[slot_ff]) : '1;
         EV_TOOL:     value = cur.palm ? TOOL_PALM : TOOL_FINGER;
         EV_MT_X,
         EV_X:        value = VALUE_BITS'(cur.x);
         EV_MT_Y,
         EV_Y:        value = {{(VALUE_BITS - 13){cur.y[12]}}, cur.y};
         EV_MAJOR,
         EV_WIDTH:    value = VALUE_BITS'(cur.major);
         EV_PRESSURE: value = VALUE_BITS'(cur.press);
         EV_TOUCH,
         EV_FINGER:   value = VALUE_BITS'(any_ff);
         EV_BUTTON:   value = VALUE_BITS'(button_ff);
         default:     value = '0;
      endcase

      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      code_ff <= code_in;
      if (load && state_ff == ST_IDLE) begin
         lanes_ff  <= lanes;
         tids_ff   <= tids;
         any_ff    <= any_touch;
         button_ff <= button;
      end
      if (emit) begin
         out_code_ff  <= code_ff;
         out_value_ff <= value;
         out_last_ff  <= emit_last;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - VALUE_BITS - CODE_BITS)'(0), out_value_ff, out_code_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

@@ sv/touchpad_report_to_mt_events.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// touchpad_report_to_mt_events
// Turns touchpad reports into a stream of multitouch events, keeping the
// per-slot contact state and the tracking id counter.
// ---------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | report id, status byte, five contact records
//  rsp_    | out       | event code and value, tlast on the closing sync
//  csr_    | in        | register writes, no read-back
//
// A matching report is captured when it is accepted; the sequencer then walks
// its events slot by slot and steps over each slot that is not reported. With
// all five slots present a report gives 42 events, the most any report needs.
// A report with another id is accepted and gives nothing.
// The sequencer holds while an event waits in the output register and
// rsp_tready is low.
// Reset is synchronous and restores registers, slot state and id counter.
// ---------------------------------------------------------------------------
module touchpad_report_to_mt_events (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // [7:0] report_id, [15:8] status_byte, [55:16] record_0, [95:56] record_1,
   // [135:96] record_2, [175:136] record_3, [215:176] record_4
   input  wire logic [tprmt_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // [3:0] event_code, [20:4] event_value, [23:21] zero
   output logic [tprmt_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   output logic                                        rsp_tlast,
   input  wire logic                                   csr_wr_en,
   input  wire logic [tprmt_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire logic [tprmt_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import tprmt_pkg::*;

   cfg_type                                   cfg_ff, cfg_in;
   logic [SLOT_COUNT-1:0]                     active_ff, active_in;
   logic [SLOT_COUNT-1:0]                     palm_ff, palm_in;
   logic [SLOT_COUNT-1:0][TRACK_ID_BITS-1:0]  track_ff, track_in;
   logic [TRACK_ID_BITS-1:0]                  next_id_ff, next_id_in;

   logic [RECORD_COUNT-1:0][RECORD_BITS-1:0]  records;
   lane_type [SLOT_COUNT-1:0]                 lanes;
   logic [SLOT_COUNT-1:0][TRACK_ID_BITS-1:0]  new_tid;
   logic [7:0]                                report_id;
   logic [7:0]                                status;
   logic                                      busy;
   logic                                      load;
   logic                                      any_touch;
   logic [TRACK_ID_BITS-1:0]                  id_count;

   always_comb begin
      report_id = req_tdata[7:0];
      status    = req_tdata[15:8];
      for (int k = 0; k < RECORD_COUNT; k++) begin
         records[k] = req_tdata[16 + k * RECORD_BITS +: RECORD_BITS];
      end
      any_touch = |status[STATUS_BASE +: SLOT_COUNT];
   end

   assign req_tready = !busy;
   assign load       = req_tvalid && req_tready && (report_id == cfg_ff.report_id);

   for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_lane
      tprmt_lane u_lane (
         .lane_idx (SLOT_W'(s)),
         .status   (status),
         .records  (records),
         .cfg      (cfg_ff),
         .active   (active_ff[s]),
         .is_palm  (palm_ff[s]),
         .info     (lanes[s])
      );
   end

   // hand out fresh ids in slot order
   always_comb begin
      id_count = next_id_ff;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         new_tid[s] = lanes[s].needs_new ? id_count : track_ff[s];
         if (lanes[s].needs_new) begin
            id_count = id_count + TRACK_ID_BITS'(1);
         end
      end
      next_id_in = load ? id_count : next_id_ff;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         active_in[s] = load ? lanes[s].present : active_ff[s];
         palm_in[s]   = load ? lanes[s].palm    : palm_ff[s];
         track_in[s]  = load ? new_tid[s]       : track_ff[s];
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_REPORT_ID:  cfg_in.report_id  = csr_wdata[7:0];
            CSR_Y_FLIP:     cfg_in.y_flip     = csr_wdata[11:0];
            CSR_PALM_MAJOR: cfg_in.palm_major = csr_wdata[3:0];
            CSR_PALM_PRESS: cfg_in.palm_press = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.report_id  <= RESET_REPORT_ID;
         cfg_ff.y_flip     <= RESET_Y_FLIP;
         cfg_ff.palm_major <= RESET_PALM_MAJOR;
         cfg_ff.palm_press <= RESET_PALM_PRESS;
         active_ff         <= '0;
         palm_ff           <= '0;
         track_ff          <= '0;
         next_id_ff        <= '0;
      end else begin
         cfg_ff     <= cfg_in;
         active_ff  <= active_in;
         palm_ff    <= palm_in;
         track_ff   <= track_in;
         next_id_ff <= next_id_in;
      end
   end

   tprmt_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .lanes      (lanes),
      .tids       (new_tid),
      .any_touch  (any_touch),
      .button     (status[0]),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ sim/touchpad_report_to_mt_events_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// touchpad_report_to_mt_events_tb
// Self-checking bench for the touchpad report to multitouch event block.
// Reports are sent through a queue-fed driver. Each accepted report is
// expanded into its expected events by a local slot tracker. A monitor
// compares every event transaction in order. Several register settings are
// used, with random idling on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
module touchpad_report_to_mt_events_tb;
   import tprmt_pkg::*;

   localparam int          HALF_PERIOD   = 4;
   localparam int          RESET_CYCLES  = 5;
   localparam int          SETTLE_CYCLES = 64;
   localparam int          HOLD_CYCLES   = 600;
   localparam int          CYCLE_LIMIT   = 1500000;
   localparam logic [16:0] RELEASE_ID    = 17'h1ffff;

   // records[0] sits just above the status byte, as on req_tdata
   typedef struct packed {
      logic [4:0][39:0] records;
      logic [7:0]       status;
      logic [7:0]       report_id;
   } report_type;

   typedef struct {
      event_code_type code;
      logic [16:0]    val;
      logic           last;
   } mt_event_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // [7:0] report_id, [15:8] status_byte, [55:16] record_0 .. [215:176] record_4
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [3:0] event_code, [20:4] event_value, [23:21] zero
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_wr_en  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   touchpad_report_to_mt_events dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Local copy of the registers and of the slot tracker
   cfg_type     model_cfg = '{RESET_REPORT_ID, RESET_Y_FLIP, RESET_PALM_MAJOR,
                              RESET_PALM_PRESS};
   logic [4:0]  track_active = '0;
   logic [4:0]  track_palm   = '0;
   logic [15:0] track_id [5] = '{default: '0};
   logic [15:0] next_id      = '0;

   report_type   report_backlog [$];
   mt_event_type pending_events [$];
   mt_event_type want_event;

   // Contact plan used to build well-formed report sequences
   logic [4:0] plan_on   = '0;
   logic [4:0] plan_palm = '0;

   bit          sender_gaps_on   = 1'b1;
   bit          receiver_gaps_on = 1'b1;
   logic        hold_go          = 1'b0;
   int unsigned hold_left        = 0;
   int unsigned send_wait        = 0;
   int unsigned recv_wait        = 0;
   int unsigned cycle_count      = 0;
   int unsigned error_count      = 0;
   int unsigned reports_sent     = 0;
   int unsigned reports_matched  = 0;
   int unsigned events_checked   = 0;
   int unsigned register_writes  = 0;

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic void push_event(input event_code_type code, input logic [16:0] val,
                                      input logic last);
      pending_events.push_back('{code, val, last});
   endfunction

   // Expand one accepted report into the events it must produce
   function automatic void expand_report(input report_type rpt);
      int unsigned used;
      int unsigned s;
      logic        present;
      logic        palm;
      logic        any;
      logic [39:0] rec;
      logic [11:0] raw_y;
      logic [16:0] pos_x;
      logic [16:0] pos_y;
      logic [16:0] major;
      logic [16:0] press;
      used = 0;
      any  = 1'b0;
      if (rpt.report_id != model_cfg.report_id)
         return;
      reports_matched++;
      for (s = 0; s < SLOT_COUNT; s++) begin
         present = rpt.status[STATUS_BASE + s];
         rec     = rpt.records[used];
         palm    = rec[15];
         if (present) begin
            any = 1'b1;
            // new contact or tool change takes a fresh id
            if (!track_active[s] || track_palm[s] != palm) begin
               track_active[s] = 1'b1;
               track_palm[s]   = palm;
               track_id[s]     = next_id;
               next_id         = next_id + 16'd1;
            end
         end
         if (present || track_active[s]) begin
            if (!present)
               track_active[s] = 1'b0;
            push_event(EV_SLOT, 17'(s), 1'b0);
            push_event(EV_TRACK_ID, track_active[s] ? {1'b0, track_id[s]} : RELEASE_ID, 1'b0);
            push_event(EV_TOOL, track_palm[s] ? TOOL_PALM : TOOL_FINGER, 1'b0);
            if (present) begin
               pos_x = 17'({rec[39:36], rec[31:24]});
               raw_y = {rec[35:32], rec[23:16]};
               pos_y = 17'(model_cfg.y_flip) - 17'(raw_y);
               major = palm ? 17'(model_cfg.palm_major) : 17'(rec[14:12]);
               press = palm ? 17'(model_cfg.palm_press) : 17'(rec[6:0]);
               push_event(EV_MT_X, pos_x, 1'b0);
               push_event(EV_MT_Y, pos_y, 1'b0);
               push_event(EV_MAJOR, major, 1'b0);
               push_event(EV_PRESSURE, press, 1'b0);
               if (used == 0) begin
                  push_event(EV_X, pos_x, 1'b0);
                  push_event(EV_Y, pos_y, 1'b0);
                  push_event(EV_WIDTH, major, 1'b0);
               end
            end
         end
         if (present)
            used++;
      end
      push_event(EV_TOUCH, 17'(any), 1'b0);
      push_event(EV_FINGER, 17'(any), 1'b0);
      push_event(EV_BUTTON, 17'(rpt.status[0]), 1'b0);
      push_event(EV_SYNC, 17'd0, 1'b1);
   endfunction

   // Random 40-bit contact record with the palm flag forced
   function automatic logic [39:0] contact(input logic palm);
      logic [39:0] rec;
      rec     = {8'($urandom), $urandom};
      rec[15] = palm;
      return rec;
   endfunction

   function automatic logic [4:0][39:0] random_records();
      logic [4:0][39:0] recs;
      for (int k = 0; k < 5; k++)
         recs[k] = {8'($urandom), $urandom};
      return recs;
   endfunction

   task automatic add_report(input logic [7:0] id, input logic [7:0] status,
                             input logic [4:0][39:0] recs);
      report_backlog.push_back('{recs, status, id});
   endtask

   // Mostly coherent contact sequences, with wrong ids and garbled status mixed in
   task automatic queue_random_reports(input int unsigned count);
      int unsigned      roll;
      int unsigned      used;
      logic [4:0][39:0] recs;
      logic [7:0]       status;
      for (int unsigned n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         recs = random_records();
         if (roll < 8) begin
            add_report(model_cfg.report_id ^ 8'($urandom_range(1, 255)), 8'($urandom), recs);
         end else if (roll < 14) begin
            add_report(model_cfg.report_id, 8'($urandom), recs);
         end else begin
            for (int s = 0; s < 5; s++) begin
               if ($urandom_range(0, 99) < 18)
                  plan_on[s] = ~plan_on[s];
               if (plan_on[s] && $urandom_range(0, 99) < 8)
                  plan_palm[s] = ~plan_palm[s];
            end
            used = 0;
            for (int s = 0; s < 5; s++) begin
               if (plan_on[s]) begin
                  recs[used] = contact(plan_palm[s]);
                  used++;
               end
            end
            status = {plan_on, 3'($urandom)};
            add_report(model_cfg.report_id, status, recs);
         end
      end
   endtask

   task automatic write_register(input csr_index_type idx, input logic [11:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      register_writes++;
      case (idx)
         CSR_REPORT_ID:  model_cfg.report_id  = val[7:0];
         CSR_Y_FLIP:     model_cfg.y_flip     = val;
         CSR_PALM_MAJOR: model_cfg.palm_major = val[3:0];
         CSR_PALM_PRESS: model_cfg.palm_press = val[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [7:0] id, input logic [11:0] y_flip,
                                input logic [3:0] major, input logic [7:0] press);
      write_register(CSR_PALM_PRESS, 12'(press));
      write_register(CSR_REPORT_ID, 12'(id));
      write_register(CSR_PALM_MAJOR, 12'(major));
      write_register(CSR_Y_FLIP, y_flip);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold until every queued report is taken and every event has come back
   task automatic wait_for_drain();
      while (report_backlog.size() != 0 || req_tvalid || pending_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expand_report(report_type'(req_tdata));
            reports_sent++;
            send_wait = sender_gaps_on ? $urandom_range(0, 15) : 0;
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (report_backlog.size() != 0) begin
               req_tdata  <= report_backlog.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            events_checked++;
            if (pending_events.size() == 0) begin
               report_mismatch($sformatf("event code %0d arrived with nothing pending",
                                         rsp_tdata[3:0]));
            end else begin
               want_event = pending_events.pop_front();
               if (rsp_tdata[3:0] !== want_event.code)
                  report_mismatch($sformatf("event code %0d, wanted %0d",
                                            rsp_tdata[3:0], want_event.code));
               if (rsp_tdata[20:4] !== want_event.val)
                  report_mismatch($sformatf("event %0d value 0x%05h, wanted 0x%05h",
                                            want_event.code, rsp_tdata[20:4],
                                            want_event.val));
               if (rsp_tlast !== want_event.last)
                  report_mismatch($sformatf("event %0d tlast %b, wanted %b",
                                            want_event.code, rsp_tlast, want_event.last));
            end
            recv_wait = receiver_gaps_on ? $urandom_range(0, 15) : 0;
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         rsp_tready <= (recv_wait == 0) && (hold_left == 0);
      end
   end

   // Long output hold-off, counted on its own
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_go)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d events outstanding", cycle_count,
                  pending_events.size());
         $display("touchpad_report_to_mt_events regression: fail");
         $finish;
      end
   end

   initial begin
      logic [4:0][39:0] recs;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed reports at the reset settings
      add_report(RESET_REPORT_ID, 8'h00, '0);
      // every slot as palm, raw y above the flip value, bits 1 and 2 set
      add_report(RESET_REPORT_ID, 8'hff, {5{40'hff_ffff_ffff}});
      // every slot switches to finger with all-zero records
      add_report(RESET_REPORT_ID, 8'hf8, '0);
      // raw y equal to the flip value, x at its maximum
      recs = random_records();
      recs[0] = 40'hf6_ff_de_7f_7f;
      add_report(RESET_REPORT_ID, 8'hf9, recs);
      // release of every slot, each keeping its last tool
      add_report(RESET_REPORT_ID, 8'h01, random_records());
      // only the last slot, as palm: it is the first present contact
      recs = random_records();
      recs[0] = contact(1'b1);
      add_report(RESET_REPORT_ID, 8'h80, recs);
      // last slot released as palm while the first slot appears
      recs = random_records();
      recs[0] = contact(1'b0);
      add_report(RESET_REPORT_ID, 8'h0e, recs);
      // ids that must be dropped
      add_report(8'h00, 8'hf8, random_records());
      add_report(8'hff, 8'hf8, random_records());
      add_report(RESET_REPORT_ID ^ 8'h01, 8'h09, random_records());
      // two slots with garbage in the unused records
      recs = {5{40'hff_ffff_ffff}};
      recs[0] = contact(1'b0);
      recs[1] = contact(1'b1);
      add_report(RESET_REPORT_ID, 8'h50, recs);
      // same slots, tool flipped on one of them
      recs[0] = contact(1'b0);
      recs[1] = contact(1'b0);
      add_report(RESET_REPORT_ID, 8'h56, recs);
      add_report(RESET_REPORT_ID, 8'h07, random_records());
      queue_random_reports(95);
      wait_for_drain();

      // Lowest register values
      apply_setting(8'h00, 12'h000, 4'h0, 8'h00);
      queue_random_reports(95);
      wait_for_drain();

      // Highest register values; output held off while reports keep coming
      apply_setting(8'hff, 12'hfff, 4'hf, 8'hff);
      sender_gaps_on = 1'b0;
      @(posedge clock);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      queue_random_reports(95);
      wait_for_drain();

      // Random registers, no idling on either side
      apply_setting(8'($urandom), 12'($urandom), 4'($urandom), 8'($urandom));
      receiver_gaps_on = 1'b0;
      queue_random_reports(95);
      wait_for_drain();

      // Random registers, idling back on
      apply_setting(8'($urandom), 12'($urandom), 4'($urandom), 8'($urandom));
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      queue_random_reports(80);
      wait_for_drain();

      if (pending_events.size() != 0)
         report_mismatch($sformatf("%0d events never arrived", pending_events.size()));
      $display("Ran %0d reports (%0d matched the accepted id) and checked %0d events,",
               reports_sent, reports_matched, events_checked);
      $display("across %0d register writes in five settings, with stalls and a long hold-off.",
               register_writes);
      if (error_count == 0)
         $display("touchpad_report_to_mt_events regression: pass");
      else
         $display("touchpad_report_to_mt_events regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
sv/tprmt_pkg.sv
sv/tprmt_lane.sv
sv/tprmt_emit.sv
sv/touchpad_report_to_mt_events.sv
sim/touchpad_report_to_mt_events_tb.sv
